>>> design/grd_pkg.sv
// Shared constants, codes and types for the graph reachability engine.
package grd_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int ADDR_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int ROW_W        = MAX_VERTICES;
	localparam int VC_W         = 7;
	localparam int VID_W        = 6;
	localparam logic [VC_W-1:0] VC_RESET = 7'd64;

	typedef enum logic [1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_ADD   = 2'd1,
		FUNC_QUERY = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD_RS,
		ST_ADD_WS,
		ST_ADD_RD,
		ST_ADD_WD,
		ST_SEED,
		ST_POP,
		ST_POPW,
		ST_LOAD,
		ST_PUSH,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic              any;
		logic [ADDR_W-1:0] idx;
	} pick_t;

endpackage

>>> design/grd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module grd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/grd_pick.sv
// Lowest-set-bit finder shared by every push of the search.
module grd_pick (
	input  logic [grd_pkg::ROW_W-1:0] vec,
	output grd_pkg::pick_t            pick
);
	import grd_pkg::*;

	always_comb begin
		pick.any = |vec;
		pick.idx = '0;
		for (int i = ROW_W - 1; i >= 0; i--) begin
			if (vec[i]) begin
				pick.idx = ADDR_W'(i);
			end
		end
	end

endmodule

>>> design/graph_reachability_dfs_core.sv
// Top level of the undirected graph reachability engine.
//
// Takes one word at a time: clear graph, add undirected edge, or path query, and
// returns one result word (status, path_found) for each. The adjacency matrix
// lives in a 64x64-bit RAM with one valid flop per row, so a clear resets only the
// valid flops and a row never written reads as empty. An add-edge is two read-
// modify-write passes, first on the source row and then on the destination row. A
// query runs a depth-first search over a stack RAM with visited marks in flops. The
// source is pushed through the shared lowest-bit finder like any other vertex,
// then each vertex costs a pop (POP, POPW), a row read (LOAD) and one push per
// fresh neighbour plus one. The search is bounded by the single read port of each
// RAM and the shared lowest-bit finder; a hit on the target ends the search early.
// A source equal to the target, an out-of-range vertex, a clear and the unused
// code go straight to the result state. in_stall is high while a word is at work;
// a finished result sits in the output register and does not hold off the next
// word, though the result after it waits until that register is taken. The user
// must write vertex_count only while idle; the block itself does not enforce it.
// Values above 64 act as 64 and zero makes every edge and query an error.
module graph_reachability_dfs_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [grd_pkg::VC_W-1:0]  cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                func,
	input  logic [grd_pkg::VID_W-1:0] src,
	input  logic [grd_pkg::VID_W-1:0] dest,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      status,
	output logic                      path_found
);
	import grd_pkg::*;

	// control state
	state_t            state_q, state_d;
	logic [VC_W-1:0]   vertex_count_q;
	logic [ROW_W-1:0]  row_valid_q;
	logic [CNT_W-1:0]  depth_q;
	logic              out_valid_q;

	// payload registers
	logic [ADDR_W-1:0] src_q, dest_q;
	logic [ROW_W-1:0]  visited_q;
	logic [ROW_W-1:0]  fresh_q;
	logic              rowv_s1;
	logic              res_status_q, res_found_q;
	logic              status_q, found_q;

	// decode of the incoming word
	func_t             in_func;
	logic              accept;
	logic [VC_W-1:0]   live_n;
	logic              bad_vtx;
	logic [ROW_W-1:0]  allowed;

	// RAM ports
	logic              adj_we;
	logic [ADDR_W-1:0] adj_waddr, adj_raddr;
	logic [ROW_W-1:0]  adj_wdata, adj_rdata, row;
	logic              stk_we;
	logic [ADDR_W-1:0] stk_waddr, stk_raddr, stk_rdata;
	logic              res_load;
	logic              out_take;
	pick_t             pick;

	assign in_func  = func_t'(func);
	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_take = out_valid_q && !out_stall;
	assign res_load = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign path_found = found_q;

	// effective vertex count, capped at the matrix size
	assign live_n  = (vertex_count_q > VC_W'(MAX_VERTICES)) ? VC_W'(MAX_VERTICES)
		: vertex_count_q;
	assign bad_vtx = ({1'b0, src} >= live_n) || ({1'b0, dest} >= live_n);

	always_comb begin
		for (int i = 0; i < ROW_W; i++) begin
			allowed[i] = (VC_W'(i) < live_n);
		end
	end

	// a row never written since the last clear reads as empty
	assign row = rowv_s1 ? adj_rdata : '0;

	grd_ram #(.WIDTH(ROW_W), .DEPTH(MAX_VERTICES)) u_adj (
		.clk   (clk),
		.we    (adj_we),
		.waddr (adj_waddr),
		.wdata (adj_wdata),
		.raddr (adj_raddr),
		.rdata (adj_rdata)
	);

	grd_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_VERTICES)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (pick.idx),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	grd_pick u_pick (
		.vec  (fresh_q),
		.pick (pick)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (in_func)
						FUNC_ADD:   state_d = bad_vtx ? ST_FIN : ST_ADD_RS;
						FUNC_QUERY: state_d = (bad_vtx || src == dest) ? ST_FIN : ST_SEED;
						default:    state_d = ST_FIN;
					endcase
				end
			end
			ST_ADD_RS: state_d = ST_ADD_WS;
			ST_ADD_WS: state_d = ST_ADD_RD;
			ST_ADD_RD: state_d = ST_ADD_WD;
			ST_ADD_WD: state_d = ST_FIN;
			ST_SEED:   state_d = ST_PUSH;
			ST_POP:    state_d = (depth_q == '0) ? ST_FIN : ST_POPW;
			ST_POPW:   state_d = (stk_rdata == dest_q) ? ST_FIN : ST_LOAD;
			ST_LOAD:   state_d = ST_PUSH;
			ST_PUSH:   state_d = pick.any ? ST_PUSH : ST_POP;
			ST_FIN:    state_d = res_load ? ST_IDLE : ST_FIN;
			default:   state_d = ST_IDLE;
		endcase
	end

	// RAM control
	always_comb begin
		adj_we    = 1'b0;
		adj_waddr = src_q;
		adj_wdata = row | (ROW_W'(1) << dest_q);
		adj_raddr = src_q;
		stk_we    = 1'b0;
		stk_waddr = depth_q[ADDR_W-1:0];
		stk_raddr = ADDR_W'(depth_q - 1'b1);
		unique case (state_q)
			ST_ADD_WS: begin
				adj_we = 1'b1;
			end
			ST_ADD_RD: begin
				adj_raddr = dest_q;
			end
			ST_ADD_WD: begin
				adj_we    = 1'b1;
				adj_waddr = dest_q;
				adj_wdata = row | (ROW_W'(1) << src_q);
			end
			ST_POPW: begin
				adj_raddr = stk_rdata;
			end
			ST_PUSH: begin
				stk_we = pick.any;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			vertex_count_q <= VC_RESET;
			row_valid_q    <= '0;
			depth_q        <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				vertex_count_q <= cfg_data;
			end
			if (accept && in_func == FUNC_CLEAR) begin
				row_valid_q <= '0;
			end else if (adj_we) begin
				row_valid_q[adj_waddr] <= 1'b1;
			end
			unique case (state_q)
				ST_SEED: depth_q <= '0;
				ST_POP:  if (depth_q != '0) depth_q <= depth_q - 1'b1;
				ST_PUSH: if (pick.any) depth_q <= depth_q + 1'b1;
				default: begin
				end
			endcase
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// seed the stack with the source vertex: the shared finder sees it in fresh_q
	// payload registers
	always_ff @(posedge clk) begin
		rowv_s1 <= row_valid_q[adj_raddr];
		if (accept) begin
			src_q        <= src[ADDR_W-1:0];
			dest_q       <= dest[ADDR_W-1:0];
			res_status_q <= (in_func == FUNC_ADD || in_func == FUNC_QUERY) && bad_vtx;
			res_found_q  <= !bad_vtx && in_func == FUNC_QUERY && src == dest;
		end
		unique case (state_q)
			ST_SEED: begin
				visited_q <= ROW_W'(1) << src_q;
				fresh_q   <= ROW_W'(1) << src_q;
			end
			ST_POPW: begin
				if (stk_rdata == dest_q) begin
					res_found_q <= 1'b1;
				end
			end
			ST_LOAD: begin
				fresh_q   <= row & allowed & ~visited_q;
				visited_q <= visited_q | (row & allowed);
			end
			ST_PUSH: begin
				fresh_q <= fresh_q & (fresh_q - 1'b1);
			end
			default: begin
			end
		endcase
		if (res_load) begin
			status_q <= res_status_q;
			found_q  <= res_found_q;
		end
	end

endmodule
